// File: sv/battery_monitor_reading_converter_defines.svh
// assertion macros for the battery-monitor reading converter
// taken in by every rtl file that carries checks; no other dependencies
`ifndef BATTERY_MONITOR_READING_CONVERTER_DEFINES_SVH
`define BATTERY_MONITOR_READING_CONVERTER_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define BRMC_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("brmc: same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define BRMC_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("brmc: next-cycle check failed");

`endif

// File: sv/brmc_pkg.sv
// shared types, constants and the divider step for the reading converter
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package brmc_pkg;

   // conversion kinds
   localparam logic [2:0] KIND_CELL    = 3'd0;
   localparam logic [2:0] KIND_PACK    = 3'd1;
   localparam logic [2:0] KIND_CURRENT = 3'd2;
   localparam logic [2:0] KIND_TEMP    = 3'd3;
   localparam logic [2:0] KIND_TRIP    = 3'd4;

   // register indexes (word address)
   localparam logic [1:0] REG_OFFSET = 2'd0;
   localparam logic [1:0] REG_GAIN1  = 2'd1;
   localparam logic [1:0] REG_GAIN2  = 2'd2;
   localparam logic [1:0] REG_SENSE  = 2'd3;

   localparam logic [7:0]  SENSE_RESET  = 8'd8;
   localparam logic [8:0]  GAIN_BASE    = 9'd365;
   localparam logic [14:0] MV_DIVISOR   = 15'd1000;
   localparam logic [14:0] TEMP_DIVISOR = 15'd42;
   localparam logic [14:0] SENSE_SCALE  = 15'd100;
   localparam logic [10:0] CUR_FACTOR   = 11'd844;
   localparam logic [10:0] TEMP_SLOPE   = 11'd382;
   localparam logic [10:0] TRIP_FACTOR  = 11'd1000;
   localparam logic [26:0] TEMP_BIAS    = 27'd1305000;

   localparam logic [16:0] POS_MAG_MAX = 17'd32767;
   localparam logic [16:0] NEG_MAG_MAX = 17'd32768;
   localparam logic [16:0] SMALL_MAG   = 17'd3;
   localparam logic signed [16:0] SAT_POS = 17'sd32767;
   localparam logic signed [16:0] SAT_NEG = -17'sd32768;
   localparam logic signed [16:0] U16_MAX = 17'sd65535;

   localparam int DIV_STEPS_C = 6;
   localparam int DIV_STEPS_D = 6;
   localparam int DIV_STEPS_E = 5;

   typedef struct packed {
      logic [2:0]  kind;
      logic [15:0] raw_value;
   } req_type;

   typedef struct packed {
      logic signed [16:0] converted;
      logic               saturated;
   } rsp_type;

   typedef struct packed {
      logic signed [7:0] off;
      logic [8:0]        gain;
      logic [7:0]        sense;
   } cal_type;

   typedef struct packed {
      logic       valid;
      logic [2:0] kind;
      logic       neg;    // result sign (current, temperature)
      logic       dneg;   // trip difference below zero
   } tag_type;

   typedef struct packed {
      tag_type     tag;
      logic [26:0] dividend;
      logic [14:0] divisor;
   } front_out_type;

   typedef struct packed {
      tag_type     tag;
      logic        ovf;
      logic [16:0] quo;
   } div_out_type;

   typedef struct packed {
      logic [14:0] rem;
      logic [16:0] num;
      logic [16:0] quo;
   } div_state_type;

   // one restoring-division step: one quotient bit
   function automatic div_state_type div_step(input div_state_type s,
                                              input logic [14:0] divisor);
      div_state_type r;
      logic [15:0]   trial;
      trial = {s.rem, s.num[16]};
      r.num = {s.num[15:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
         r.rem = 15'(trial - {1'b0, divisor});
         r.quo = {s.quo[15:0], 1'b1};
      end else begin
         r.rem = trial[14:0];
         r.quo = {s.quo[15:0], 1'b0};
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// File: sv/brmc_front.sv
// front end: operand select and multiply, then dividend and sign forming
// depends on brmc_pkg
`timescale 1ns / 1ps
`default_nettype none

module brmc_front (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    in_valid,
   input  brmc_pkg::req_type      in_data,
   input  brmc_pkg::cal_type      cal,
   output brmc_pkg::front_out_type out
);
   import brmc_pkg::*;

   logic              s_neg;
   logic [15:0]       s_mag;
   logic [17:0]       diff;
   logic [7:0]        sense_eff;
   logic [16:0]       op_a;
   logic [10:0]       op_b;
   logic [27:0]       mult;
   logic [14:0]       divisor_a;
   tag_type           tag_a;

   logic [26:0]       prod_ff,    prod_in;
   logic [14:0]       div_a_ff,   div_a_in;
   tag_type           tag_a_ff,   tag_a_in;
   front_out_type     out_ff,     out_in;

   // stage a: pick the multiplier operands and divisor per kind
   always_comb begin
      s_neg     = in_data.raw_value[15];
      s_mag     = s_neg ? 16'(~in_data.raw_value + 16'd1) : in_data.raw_value;
      diff      = {2'b00, in_data.raw_value} - {{10{cal.off[7]}}, cal.off};
      sense_eff = (cal.sense == 8'd0) ? 8'd1 : cal.sense;
      tag_a.valid = in_valid;
      tag_a.kind  = in_data.kind;
      tag_a.neg   = 1'b0;
      tag_a.dneg  = 1'b0;
      op_a      = '0;
      op_b      = '0;
      divisor_a = 15'd1;
      unique case (in_data.kind)
         KIND_CELL: begin
            op_a      = {1'b0, in_data.raw_value};
            op_b      = {2'b00, cal.gain};
            divisor_a = MV_DIVISOR;
         end
         KIND_PACK: begin
            op_a      = {1'b0, in_data.raw_value};
            op_b      = {cal.gain, 2'b00};
            divisor_a = MV_DIVISOR;
         end
         KIND_CURRENT: begin
            op_a      = {1'b0, s_mag};
            op_b      = CUR_FACTOR;
            divisor_a = 15'({7'd0, sense_eff} * SENSE_SCALE);
            tag_a.neg = s_neg;
         end
         KIND_TEMP: begin
            op_a      = {1'b0, in_data.raw_value};
            op_b      = TEMP_SLOPE;
            divisor_a = TEMP_DIVISOR;
         end
         KIND_TRIP: begin
            tag_a.dneg = diff[17];
            op_a       = diff[17] ? 17'd0 : diff[16:0];
            op_b       = TRIP_FACTOR;
            divisor_a  = {2'b00, cal.gain, 4'b0000};
         end
         default: ;
      endcase
      mult     = {11'd0, op_a} * {17'd0, op_b};
      prod_in  = mult[26:0];
      div_a_in = divisor_a;
      tag_a_in = tag_a;
   end

   // stage b: temperature numerator is bias minus product, split into sign and size
   always_comb begin
      out_in.tag      = tag_a_ff;
      out_in.divisor  = div_a_ff;
      out_in.dividend = prod_ff;
      if (tag_a_ff.kind == KIND_TEMP) begin
         if (prod_ff > TEMP_BIAS) begin
            out_in.tag.neg  = 1'b1;
            out_in.dividend = prod_ff - TEMP_BIAS;
         end else begin
            out_in.dividend = TEMP_BIAS - prod_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      div_a_ff <= div_a_in;
      if (reset) begin
         tag_a_ff <= '0;
         out_ff   <= '0;
      end else begin
         tag_a_ff <= tag_a_in;
         out_ff   <= out_in;
      end
   end

   assign out = out_ff;

endmodule

`default_nettype wire

// File: sv/brmc_div.sv
// three-stage restoring divider, 17 quotient bits plus overflow flag
// depends on brmc_pkg (div_step)
`timescale 1ns / 1ps
`default_nettype none

module brmc_div (
   input  wire                     clock,
   input  wire                     reset,
   input  brmc_pkg::front_out_type in,
   output brmc_pkg::div_out_type   out
);
   import brmc_pkg::*;

   div_state_type st_c, st_d, st_e;
   logic          ovf_c;

   div_state_type st_c_ff,  st_c_in;
   div_state_type st_d_ff,  st_d_in;
   tag_type       tag_c_ff, tag_d_ff;
   logic          ovf_c_ff, ovf_d_ff;
   logic [14:0]   dv_c_ff,  dv_d_ff;
   div_out_type   out_ff,   out_in;

   // upper dividend bits seed the remainder; quotient overflows if they reach the divisor
   always_comb begin
      ovf_c    = {5'd0, in.dividend[26:17]} >= in.divisor;
      st_c.rem = {5'd0, in.dividend[26:17]};
      st_c.num = in.dividend[16:0];
      st_c.quo = '0;
      for (int i = 0; i < DIV_STEPS_C; i++) begin
         st_c = div_step(st_c, in.divisor);
      end
      st_c_in = st_c;
   end

   always_comb begin
      st_d = st_c_ff;
      for (int i = 0; i < DIV_STEPS_D; i++) begin
         st_d = div_step(st_d, dv_c_ff);
      end
      st_d_in = st_d;
   end

   always_comb begin
      st_e = st_d_ff;
      for (int i = 0; i < DIV_STEPS_E; i++) begin
         st_e = div_step(st_e, dv_d_ff);
      end
      out_in.tag = tag_d_ff;
      out_in.ovf = ovf_d_ff;
      out_in.quo = st_e.quo;
   end

   always_ff @(posedge clock) begin
      st_c_ff  <= st_c_in;
      ovf_c_ff <= ovf_c;
      dv_c_ff  <= in.divisor;
      st_d_ff  <= st_d_in;
      ovf_d_ff <= ovf_c_ff;
      dv_d_ff  <= dv_c_ff;
      if (reset) begin
         tag_c_ff <= '0;
         tag_d_ff <= '0;
         out_ff   <= '0;
      end else begin
         tag_c_ff <= in.tag;
         tag_d_ff <= tag_c_ff;
         out_ff   <= out_in;
      end
   end

   assign out = out_ff;

endmodule

`default_nettype wire

// File: sv/brmc_post.sv
// result stage: offset add, sign restore, clamping, output register
// depends on brmc_pkg and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none
`include "battery_monitor_reading_converter_defines.svh"

module brmc_post (
   input  wire                   clock,
   input  wire                   reset,
   input  brmc_pkg::div_out_type in,
   input  brmc_pkg::cal_type     cal,
   output logic                  rsp_strobe,
   output brmc_pkg::rsp_type     rsp_data
);
   import brmc_pkg::*;

   logic signed [18:0] off_ext;
   logic signed [18:0] off_term;
   logic signed [18:0] sum;
   logic signed [16:0] v;
   logic               sat;

   logic               strobe_ff, strobe_in;
   rsp_type            data_ff,   data_in;
   logic [2:0]         kind_ff,   kind_in;

   always_comb begin
      off_ext  = {{11{cal.off[7]}}, cal.off};
      off_term = (in.tag.kind == KIND_PACK) ? ((off_ext <<< 1) + off_ext) : off_ext;
      sum      = $signed({2'b00, in.quo}) + off_term;
      v        = '0;
      sat      = 1'b0;
      unique case (in.tag.kind)
         KIND_CELL, KIND_PACK: begin
            if (sum < 19'sd0) begin
               sat = 1'b1;
            end else if (sum > 19'sd65535) begin
               v   = U16_MAX;
               sat = 1'b1;
            end else begin
               v = $signed(sum[16:0]);
            end
         end
         KIND_CURRENT, KIND_TEMP: begin
            if (in.ovf) begin
               v   = in.tag.neg ? SAT_NEG : SAT_POS;
               sat = 1'b1;
            end else if (in.tag.neg) begin
               if (in.quo > NEG_MAG_MAX) begin
                  v   = SAT_NEG;
                  sat = 1'b1;
               end else begin
                  v = $signed(17'd0 - in.quo);
               end
            end else begin
               if (in.quo > POS_MAG_MAX) begin
                  v   = SAT_POS;
                  sat = 1'b1;
               end else begin
                  v = $signed(in.quo);
               end
            end
            // dead band around zero for current
            if (in.tag.kind == KIND_CURRENT && !sat && in.quo <= SMALL_MAG) begin
               v = '0;
            end
         end
         KIND_TRIP: begin
            if (in.tag.dneg) begin
               sat = 1'b1;
            end else begin
               v = $signed({9'd0, in.quo[7:0]});
            end
         end
         default: ;
      endcase
      strobe_in         = in.tag.valid;
      data_in.converted = v;
      data_in.saturated = sat;
      kind_in           = in.tag.kind;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= strobe_in;
      end
      data_ff <= data_in;
      kind_ff <= kind_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = data_ff;

   `BRMC_ASSERT_NOW(a_mv_not_negative, clock, reset,
      strobe_ff && (kind_ff == KIND_CELL || kind_ff == KIND_PACK),
      !data_ff.converted[16])
   `BRMC_ASSERT_NOW(a_trip_byte_range, clock, reset,
      strobe_ff && kind_ff == KIND_TRIP, data_ff.converted[16:8] == 9'd0)
   `BRMC_ASSERT_NOW(a_signed_sat_at_limit, clock, reset,
      strobe_ff && data_ff.saturated && (kind_ff == KIND_CURRENT || kind_ff == KIND_TEMP),
      data_ff.converted == SAT_POS || data_ff.converted == SAT_NEG)
   `BRMC_ASSERT_NEXT(a_trip_negative_flag, clock, reset,
      in.tag.valid && in.tag.kind == KIND_TRIP && in.tag.dneg,
      rsp_strobe && rsp_data.saturated && rsp_data.converted == 17'sd0)

endmodule

`default_nettype wire

// File: sv/battery_monitor_reading_converter.sv
// top level: calibration register file, front end, divider and result stage
// depends on brmc_pkg, brmc_front, brmc_div, brmc_post
//
//  channel   ports                                   direction   handshake
//  request   start, busy, req_data                   in          start & !busy
//  response  rsp_strobe, rsp_data                    out         strobe, one cycle
//  config    psel, penable, pwrite, paddr, pwdata,   in/out      setup + access
//            prdata, pready
//
// one item per cycle whenever busy is low; each result reaches the ports through
// the register stages: two in the front end (multiply, dividend forming), three
// in the divider (17 quotient bits, 6/6/5 per stage), one at the output. reset
// is synchronous, clears all valid bits and the offset and gain registers and
// sets the sense register to 8; busy is high only while reset is held. results
// are never held back, so nothing in the pipeline ever waits.
`timescale 1ns / 1ps
`default_nettype none

module battery_monitor_reading_converter (
   input  wire                clock,
   input  wire                reset,
   input  wire                start,
   output logic               busy,
   input  brmc_pkg::req_type  req_data,
   output logic               rsp_strobe,
   output brmc_pkg::rsp_type  rsp_data,
   input  wire                psel,
   input  wire                penable,
   input  wire                pwrite,
   input  wire  [3:0]         paddr,
   input  wire  [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);
   import brmc_pkg::*;

   logic [7:0]    offset_byte_ff,    offset_byte_in;
   logic [7:0]    gain_byte_one_ff,  gain_byte_one_in;
   logic [7:0]    gain_byte_two_ff,  gain_byte_two_in;
   logic [7:0]    sense_milliohm_ff, sense_milliohm_in;
   logic          csr_write;
   logic          req_accept;
   cal_type       cal;
   front_out_type front_out;
   div_out_type   div_out;

   assign pready     = 1'b1;
   assign busy       = reset;
   assign req_accept = start & ~busy;
   assign csr_write  = psel & penable & pwrite;

   always_comb begin
      offset_byte_in    = offset_byte_ff;
      gain_byte_one_in  = gain_byte_one_ff;
      gain_byte_two_in  = gain_byte_two_ff;
      sense_milliohm_in = sense_milliohm_ff;
      if (csr_write) begin
         unique case (paddr[3:2])
            REG_OFFSET: offset_byte_in    = pwdata[7:0];
            REG_GAIN1:  gain_byte_one_in  = pwdata[7:0];
            REG_GAIN2:  gain_byte_two_in  = pwdata[7:0];
            REG_SENSE:  sense_milliohm_in = pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_byte_ff    <= 8'd0;
         gain_byte_one_ff  <= 8'd0;
         gain_byte_two_ff  <= 8'd0;
         sense_milliohm_ff <= SENSE_RESET;
      end else begin
         offset_byte_ff    <= offset_byte_in;
         gain_byte_one_ff  <= gain_byte_one_in;
         gain_byte_two_ff  <= gain_byte_two_in;
         sense_milliohm_ff <= sense_milliohm_in;
      end
   end

   always_comb begin
      prdata = '0;
      unique case (paddr[3:2])
         REG_OFFSET: prdata[7:0] = offset_byte_ff;
         REG_GAIN1:  prdata[7:0] = gain_byte_one_ff;
         REG_GAIN2:  prdata[7:0] = gain_byte_two_ff;
         REG_SENSE:  prdata[7:0] = sense_milliohm_ff;
         default: ;
      endcase
   end

   // gain is 365 plus five bits gathered from two calibration bytes
   always_comb begin
      cal.off   = $signed(offset_byte_ff);
      cal.gain  = GAIN_BASE + {4'd0, gain_byte_one_ff[3:2], gain_byte_two_ff[7:5]};
      cal.sense = sense_milliohm_ff;
   end

   brmc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_accept),
      .in_data  (req_data),
      .cal      (cal),
      .out      (front_out)
   );

   brmc_div u_div (
      .clock (clock),
      .reset (reset),
      .in    (front_out),
      .out   (div_out)
   );

   brmc_post u_post (
      .clock      (clock),
      .reset      (reset),
      .in         (div_out),
      .cal        (cal),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire

// File: sim/tb_top.sv
// self-checking testbench for battery_monitor_reading_converter
// needs brmc_pkg and the converter rtl; the predictor below mirrors the conversions
// and checks every result in order, plus read-back of the calibration registers
`timescale 1ns / 1ps

module tb_top;
   import brmc_pkg::*;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int SETTLE_CYCLES  = 20;
   localparam int PHASE_READINGS = 125;
   localparam int N_PHASES       = 8;
   localparam int MAX_REPORTS    = 30;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   req_type     req_data = '0;
   logic        rsp_strobe;
   rsp_type     rsp_data;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [3:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   // calibration as the predictor sees it
   logic [7:0] cal_off   = 8'd0;
   logic [7:0] cal_g1    = 8'd0;
   logic [7:0] cal_g2    = 8'd0;
   logic [7:0] cal_sense = SENSE_RESET;

   rsp_type pending_readings[$];
   int      n_taken = 0;
   int      n_checked = 0;
   int      n_errors = 0;
   int      n_settings = 0;
   int      idle_cycles = 0;

   battery_monitor_reading_converter u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic longint clamp_reading(input longint v, input longint lo,
                                            input longint hi, inout logic sat);
      if (v < lo) begin
         sat = 1'b1;
         return lo;
      end
      if (v > hi) begin
         sat = 1'b1;
         return hi;
      end
      return v;
   endfunction

   function automatic rsp_type convert_reading(input req_type r);
      rsp_type res;
      longint  off, gain, raw, s, rr, d, v;
      logic    sat;
      off  = longint'($signed(cal_off));
      gain = longint'(GAIN_BASE) + longint'({cal_g1[3:2], cal_g2[7:5]});
      raw  = longint'(r.raw_value);
      v    = 0;
      sat  = 1'b0;
      case (r.kind)
         KIND_CELL: begin
            v = clamp_reading(raw * gain / 1000 + off, 0, 65535, sat);
         end
         KIND_PACK: begin
            v = clamp_reading(4 * gain * raw / 1000 + 3 * off, 0, 65535, sat);
         end
         KIND_CURRENT: begin
            s  = longint'($signed(r.raw_value));
            rr = (cal_sense == 8'd0) ? 1 : longint'(cal_sense);
            v  = clamp_reading(s * 844 / (100 * rr), -32768, 32767, sat);
            // readings within a few ma are noise
            if (v >= -3 && v <= 3) v = 0;
         end
         KIND_TEMP: begin
            v = clamp_reading((1305000 - 382 * raw) / 42, -32768, 32767, sat);
         end
         KIND_TRIP: begin
            d = raw - off;
            if (d < 0) begin
               sat = 1'b1;
            end else begin
               v = (d * 1000 / gain / 16) % 256;
            end
         end
         default: begin
            v = 0;
         end
      endcase
      res.converted = v[16:0];
      res.saturated = sat;
      return res;
   endfunction

   task automatic note_error(input string what, input longint want, input longint got);
      n_errors++;
      if (n_errors <= MAX_REPORTS)
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
   endtask

   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (pending_readings.size() == 0) begin
            note_error("unexpected result, converted", 0, $signed(rsp_data.converted));
         end else begin
            want = pending_readings.pop_front();
            n_checked++;
            if (rsp_data.converted !== want.converted)
               note_error("converted", $signed(want.converted), $signed(rsp_data.converted));
            if (rsp_data.saturated !== want.saturated)
               note_error("saturated", want.saturated, rsp_data.saturated);
         end
      end
   end

   // ends the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || (psel && penable)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, %0d results outstanding", $time,
                     pending_readings.size());
            $display("simulation failed");
            $finish;
         end
      end
   end

   // leaves start high so back-to-back items need no drop
   task automatic send_reading(input req_type it);
      start    <= 1'b1;
      req_data <= it;
      do @(posedge clock); while (busy);
      pending_readings.push_back(convert_reading(it));
      n_taken++;
   endtask

   task automatic pause_sender(input int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      @(posedge clock);
      while (pending_readings.size() != 0) @(posedge clock);
   endtask

   // setup then access; psel is left high for the caller
   task automatic csr_access(input logic wr, input logic [1:0] idx,
                             input logic [7:0] value, output logic [31:0] rdata);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= {idx, 2'b00};
      pwdata  <= {24'd0, value};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rdata = prdata;
   endtask

   task automatic write_and_verify(input logic [1:0] idx, input logic [7:0] value);
      logic [31:0] rdata;
      csr_access(1'b1, idx, value, rdata);
      csr_access(1'b0, idx, 8'd0, rdata);
      if (rdata !== {24'd0, value})
         note_error("register read-back", value, rdata);
   endtask

   task automatic set_calibration(input logic [7:0] off, input logic [7:0] g1,
                                  input logic [7:0] g2, input logic [7:0] sense);
      wait_drained();
      write_and_verify(REG_OFFSET, off);
      write_and_verify(REG_GAIN1, g1);
      write_and_verify(REG_GAIN2, g2);
      write_and_verify(REG_SENSE, sense);
      psel    <= 1'b0;
      penable <= 1'b0;
      cal_off   = off;
      cal_g1    = g1;
      cal_g2    = g2;
      cal_sense = sense;
      n_settings++;
   endtask

   function automatic req_type make_reading(input logic [2:0] kind, input logic [15:0] raw);
      req_type it;
      it.kind      = kind;
      it.raw_value = raw;
      return it;
   endfunction

   function automatic req_type random_reading();
      req_type it;
      int      pick;
      pick = $urandom_range(0, 19);
      if (pick == 19)
         it.kind = 3'($urandom_range(KIND_TRIP + 1, 7));
      else
         it.kind = 3'(pick % 5);
      pick = $urandom_range(0, 9);
      if (pick < 5)
         it.raw_value = 16'($urandom_range(0, 65535));
      else if (pick < 7)
         // near zero from both sides: trip offset and the current dead band
         it.raw_value = ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 300))
                                                   : 16'($urandom_range(65235, 65535));
      else if (pick < 9)
         // temperature clamps above roughly 7020
         it.raw_value = 16'($urandom_range(6800, 7300));
      else
         case ($urandom_range(0, 3))
            0: it.raw_value = 16'h0000;
            1: it.raw_value = 16'hFFFF;
            2: it.raw_value = 16'h7FFF;
            default: it.raw_value = 16'h8000;
         endcase
      return it;
   endfunction

   task automatic test_reset_values();
      logic [31:0] rdata;
      csr_access(1'b0, REG_OFFSET, 8'd0, rdata);
      if (rdata !== 32'd0) note_error("reset offset", 0, rdata);
      csr_access(1'b0, REG_GAIN1, 8'd0, rdata);
      if (rdata !== 32'd0) note_error("reset gain one", 0, rdata);
      csr_access(1'b0, REG_GAIN2, 8'd0, rdata);
      if (rdata !== 32'd0) note_error("reset gain two", 0, rdata);
      csr_access(1'b0, REG_SENSE, 8'd0, rdata);
      if (rdata !== {24'd0, SENSE_RESET}) note_error("reset sense", SENSE_RESET, rdata);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // reset calibration: field extremes, dead band, unused kinds
   task automatic test_directed_reset_cal();
      send_reading(make_reading(KIND_CELL, 16'h0000));
      send_reading(make_reading(KIND_CELL, 16'hFFFF));
      send_reading(make_reading(KIND_PACK, 16'hFFFF));
      send_reading(make_reading(KIND_CURRENT, 16'h7FFF));
      send_reading(make_reading(KIND_CURRENT, 16'h8000));
      send_reading(make_reading(KIND_CURRENT, 16'h0003));
      send_reading(make_reading(KIND_CURRENT, 16'hFFFC));
      send_reading(make_reading(KIND_TEMP, 16'h0000));
      send_reading(make_reading(KIND_TEMP, 16'hFFFF));
      send_reading(make_reading(KIND_TRIP, 16'hFFFF));
      for (int k = KIND_TRIP + 1; k < 8; k++)
         send_reading(make_reading(3'(k), 16'hFFFF));
   endtask

   // negative offset with zero sense, then positive offset for the negative trip case
   task automatic test_directed_extreme_cal();
      set_calibration(8'h80, 8'h0C, 8'hE0, 8'h00);
      send_reading(make_reading(KIND_CELL, 16'h0000));
      send_reading(make_reading(KIND_PACK, 16'h0000));
      send_reading(make_reading(KIND_PACK, 16'hFFFF));
      send_reading(make_reading(KIND_CURRENT, 16'h7FFF));
      send_reading(make_reading(KIND_CURRENT, 16'hFFFF));
      send_reading(make_reading(KIND_TRIP, 16'h0000));
      set_calibration(8'h7F, 8'hF3, 8'h1F, 8'hFF);
      send_reading(make_reading(KIND_TRIP, 16'h0000));
      send_reading(make_reading(KIND_TRIP, 16'h007F));
      send_reading(make_reading(KIND_CELL, 16'hFFFF));
      send_reading(make_reading(KIND_CURRENT, 16'h8000));
      send_reading(make_reading(KIND_CURRENT, 16'h001E));
   endtask

   task automatic test_random_phases();
      logic idling;
      for (int p = 0; p < N_PHASES; p++) begin
         case (p)
            0: set_calibration(8'hFF, 8'hFF, 8'hFF, 8'hFF);
            1: set_calibration(8'h7F, 8'h0C, 8'hE0, 8'h01);
            2: set_calibration(8'h80, 8'h00, 8'h00, 8'h01);
            default: set_calibration(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                     8'($urandom_range(0, 255)), 8'($urandom_range(1, 255)));
         endcase
         idling = (p != N_PHASES - 1);
         for (int i = 0; i < PHASE_READINGS; i++) begin
            send_reading(random_reading());
            if (idling && $urandom_range(0, 5) == 0)
               pause_sender($urandom_range(1, 11));
            // in phase 3, hold off mid-phase until the pipeline is empty
            if (i == PHASE_READINGS / 2 && p == 3)
               wait_drained();
         end
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_values();
      test_directed_reset_cal();
      test_directed_extreme_cal();
      test_random_phases();
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_readings.size() != 0)
         note_error("results never delivered", 0, pending_readings.size());
      $display("checked %0d of %0d readings over %0d calibration settings", n_checked,
               n_taken, n_settings);
      $display("all five conversions, unused kinds and register read-back were exercised");
      if (n_errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
